[hw/rtl/fus_pkg.sv]
// shared types and constants for the firmware update frame sequencer
package fus_pkg;

    localparam int IMAGE_DEPTH   = 65536;
    localparam int ADDR_W        = $clog2(IMAGE_DEPTH);
    localparam int PAYLOAD_BYTES = 52;
    localparam int FRAME_BYTES   = 64;
    localparam int HDR_BYTES     = 12;
    localparam int IDX_W         = 6;
    localparam int BASE_W        = 17;
    localparam logic [15:0] SIZE_LIMIT = 16'd61440;
    localparam logic [7:0]  FAIL_CODE  = 8'h46;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [1:0]  MAX_TRIES  = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_RESP    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_ERASE  = 3'd1,
        PH_PROG   = 3'd2,
        PH_VERIFY = 3'd3,
        PH_RESET  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ENTER     = 3'd1,
        EV_COMPLETE  = 3'd2,
        EV_RESET     = 3'd3,
        EV_FATAL_RSP = 3'd4,
        EV_FATAL_TMO = 3'd5
    } event_t;

    // read request and frame description sent to the frame byte generator
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  idx;
        logic              is_chunk;
        logic              prog;
        logic              crc_ins;
        logic [BASE_W-1:0] base;
        logic [15:0]       size;
        logic [15:0]       crc;
    } fus_frame_ctl_t;

endpackage

[hw/rtl/fus_crc.sv]
// byte-wide crc-16/xmodem accumulator
module fus_crc
    import fus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        en,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            crc_next = crc_next[15] ? ((crc_next << 1) ^ CRC_POLY) : (crc_next << 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= '0;
        else if (clear)
            crc_reg <= '0;
        else if (en)
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

[hw/rtl/fus_frame.sv]
// image store and frame byte generator with a registered read
module fus_frame
    import fus_pkg::*;
(
    input  logic           clk,
    input  logic           wr_en,
    input  logic [15:0]    wr_addr,
    input  logic [7:0]     wr_data,
    input  fus_frame_ctl_t ctl,
    output logic [7:0]     frame_byte
);

    logic [7:0] mem [IMAGE_DEPTH];
    logic [7:0] rd_reg;
    logic [7:0] hdr_reg;
    logic       sel_mem_reg;

    logic [IDX_W-1:0] off;
    logic [17:0]      pay_sum;
    logic             pay_ok;
    logic             in_pay;
    logic [31:0]      start32;
    logic [31:0]      end32;
    logic [7:0]       hdr;

    always_comb
    begin
        off     = ctl.idx - IDX_W'(HDR_BYTES);
        pay_sum = {1'b0, ctl.base} + 18'(off);
        pay_ok  = pay_sum < {2'b00, ctl.size};
        in_pay  = ctl.idx >= IDX_W'(HDR_BYTES);
        start32 = ctl.is_chunk ? 32'(ctl.base) : 32'd0;
        end32   = ctl.is_chunk ? (32'(ctl.base) + 32'(PAYLOAD_BYTES - 1))
                               : (32'(ctl.size) - 32'd1);
        hdr = 8'h00;
        if (in_pay)
            hdr = ctl.is_chunk ? 8'hFF : 8'h00;
        else
        begin
            case (ctl.idx[3:0])
                4'd0:    hdr = ctl.is_chunk ? 8'h01 : 8'h00;
                4'd1:    hdr = ctl.is_chunk ? {7'd0, ctl.prog} : 8'h08;
                4'd2:    hdr = ctl.crc_ins ? ctl.crc[7:0] : 8'h00;
                4'd3:    hdr = ctl.crc_ins ? ctl.crc[15:8] : 8'h00;
                4'd4:    hdr = start32[7:0];
                4'd5:    hdr = start32[15:8];
                4'd6:    hdr = start32[23:16];
                4'd7:    hdr = start32[31:24];
                4'd8:    hdr = end32[7:0];
                4'd9:    hdr = end32[15:8];
                4'd10:   hdr = end32[23:16];
                4'd11:   hdr = end32[31:24];
                default: hdr = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        if (ctl.rd_en)
        begin
            rd_reg      <= mem[pay_sum[ADDR_W-1:0]];
            hdr_reg     <= hdr;
            sel_mem_reg <= ctl.is_chunk && in_pay && pay_ok;
        end
    end

    assign frame_byte = sel_mem_reg ? rd_reg : hdr_reg;

endmodule

[hw/rtl/firmware_update_frame_sequencer.sv]
// top level: command decode, update sequencer and output register
//
// channel  dir  tdata (low bit up)                              tuser       tlast
// s_*      in   image_address[15:0] image_byte[7:0] resp[7:0]   command[1:0] -
// m_*      out  frame_byte[7:0] event_res[2:0] phase[2:0]       frame_valid  frame_last
// cfg_*    in   image_size[15:0]                                -            -
//
// load and start produce no output; a status result is registered and held until taken
// a frame runs a crc pass over all 64 bytes on the shared store read port (ST_CRC and
// ST_CRC_LAST), then sends each byte via ST_EMIT_RD, ST_EMIT_LD and a stallable ST_OUT_WAIT
// s_tready is high only while the sequencer is idle; cfg_ready is always high
// reset clears phase, chunk, retry count and crc; the image store has no reset
module firmware_update_frame_sequencer
    import fus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // image_address, image_byte, response_code
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame_byte, event_res, phase, zero pad
    output logic        m_tuser,   // frame_valid
    output logic        m_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // image_size
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_CRC_LAST,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STATUS,
        ACT_FRAME
    } act_t;

    state_t            state_reg;
    phase_t            phase_reg, phase_next;
    logic [10:0]       chunk_reg, chunk_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [1:0]        retry_reg, retry_next;
    logic [15:0]       size_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              pipe_v_reg;
    logic              is_chunk_reg, prog_reg;
    logic [BASE_W-1:0] fbase_reg;
    event_t            ev_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_fv_reg;
    logic              out_last_reg;
    event_t            out_ev_reg;
    phase_t            out_ph_reg;

    cmd_t              cmd;
    logic [7:0]        resp;
    logic              accept;
    act_t              act;
    event_t            ev;
    logic              f_chunk, f_prog;
    logic [BASE_W-1:0] f_base;
    logic [BASE_W-1:0] b;
    logic [10:0]       ch;
    logic              fail;
    logic [1:0]        r_inc;

    fus_frame_ctl_t    ctl;
    logic [7:0]        gen_byte;
    logic [15:0]       crc;
    logic              crc_clear, crc_en;

    assign cmd       = cmd_t'(s_tuser);
    assign resp      = s_tdata[31:24];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // decision for one accepted item
    always_comb
    begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        base_next  = base_reg;
        retry_next = retry_reg;
        act        = ACT_NONE;
        ev         = EV_NONE;
        f_chunk    = 1'b0;
        f_prog     = 1'b0;
        f_base     = base_reg;
        b          = base_reg;
        ch         = chunk_reg;
        fail       = (resp == FAIL_CODE);
        r_inc      = retry_reg + 2'd1;
        unique case (cmd)
            CMD_LOAD:
            begin
            end
            CMD_START:
            begin
                if (phase_reg == PH_INIT && size_reg <= SIZE_LIMIT)
                    retry_next = '0;
            end
            CMD_RESP:
            begin
                if (phase_reg != PH_ERASE && phase_reg != PH_PROG && phase_reg != PH_VERIFY)
                    retry_next = '0;
                else if (fail && r_inc == MAX_TRIES)
                begin
                    retry_next = '0;
                    phase_next = PH_INIT;
                    act        = ACT_STATUS;
                    ev         = EV_FATAL_RSP;
                end
                else
                begin
                    retry_next = fail ? r_inc : 2'd0;
                    if (phase_reg == PH_ERASE && fail)
                    begin
                        act        = ACT_FRAME;
                        phase_next = PH_ERASE;
                    end
                    else
                    begin
                        if (phase_reg == PH_ERASE)
                        begin
                            b  = '0;
                            ch = '0;
                        end
                        else if (fail && chunk_reg != 11'd0)
                        begin
                            b  = base_reg - BASE_W'(PAYLOAD_BYTES);
                            ch = chunk_reg - 11'd1;
                        end
                        if (phase_reg == PH_ERASE || phase_reg == PH_PROG)
                        begin
                            if (b < BASE_W'(size_reg))
                            begin
                                act = ACT_FRAME; f_chunk = 1'b1; f_prog = 1'b1;
                                phase_next = PH_PROG;
                            end
                            else
                            begin
                                b  = '0;
                                ch = '0;
                            end
                        end
                        if (act == ACT_NONE)
                        begin
                            if (b < BASE_W'(size_reg))
                            begin
                                act = ACT_FRAME; f_chunk = 1'b1;
                                phase_next = PH_VERIFY;
                            end
                            else
                            begin
                                act        = ACT_STATUS;
                                ev         = EV_COMPLETE;
                                phase_next = PH_RESET;
                                base_next  = b;
                                chunk_next = ch;
                            end
                        end
                        if (f_chunk)
                        begin
                            f_base     = b;
                            base_next  = b + BASE_W'(PAYLOAD_BYTES);
                            chunk_next = ch + 11'd1;
                        end
                    end
                end
            end
            CMD_TIMEOUT:
            begin
                unique case (phase_reg)
                    PH_INIT:
                    begin
                        ev = EV_ENTER;
                        if (size_reg == 16'd0)
                        begin
                            phase_next = PH_RESET;
                            act        = ACT_STATUS;
                        end
                        else
                        begin
                            phase_next = PH_ERASE;
                            act        = ACT_FRAME;
                        end
                    end
                    PH_RESET:
                    begin
                        phase_next = PH_INIT;
                        act        = ACT_STATUS;
                        ev         = EV_RESET;
                    end
                    PH_ERASE, PH_PROG, PH_VERIFY:
                    begin
                        retry_next = '0;
                        phase_next = PH_INIT;
                        act        = ACT_STATUS;
                        ev         = EV_FATAL_TMO;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctl.rd_en    = (state_reg == ST_CRC) || (state_reg == ST_EMIT_RD);
        ctl.idx      = idx_reg;
        ctl.is_chunk = is_chunk_reg;
        ctl.prog     = prog_reg;
        ctl.crc_ins  = (state_reg == ST_EMIT_RD);
        ctl.base     = fbase_reg;
        ctl.size     = size_reg;
        ctl.crc      = crc;
    end

    assign crc_clear = accept;
    assign crc_en    = ((state_reg == ST_CRC) && pipe_v_reg) || (state_reg == ST_CRC_LAST);

    fus_frame u_frame (
        .clk        (clk),
        .wr_en      (accept && cmd == CMD_LOAD),
        .wr_addr    (s_tdata[15:0]),
        .wr_data    (s_tdata[23:16]),
        .ctl        (ctl),
        .frame_byte (gen_byte)
    );

    fus_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (crc_clear),
        .en    (crc_en),
        .data  (gen_byte),
        .crc   (crc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_INIT;
            chunk_reg     <= '0;
            base_reg      <= '0;
            retry_reg     <= '0;
            size_reg      <= '0;
            idx_reg       <= '0;
            pipe_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        phase_reg <= phase_next;
                        chunk_reg <= chunk_next;
                        base_reg  <= base_next;
                        retry_reg <= retry_next;
                        ev_reg    <= ev;
                        out_ph_reg <= phase_next;
                        is_chunk_reg <= f_chunk;
                        prog_reg     <= f_prog;
                        fbase_reg    <= f_base;
                        idx_reg      <= '0;
                        pipe_v_reg   <= 1'b0;
                        if (act == ACT_STATUS)
                        begin
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= 8'h00;
                            out_fv_reg    <= 1'b0;
                            out_last_reg  <= 1'b1;
                            out_ev_reg    <= ev;
                            state_reg     <= ST_OUT_WAIT;
                        end
                        else if (act == ACT_FRAME)
                            state_reg <= ST_CRC;
                    end
                end
                ST_CRC:
                begin
                    pipe_v_reg <= 1'b1;
                    idx_reg    <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(FRAME_BYTES - 1))
                        state_reg <= ST_CRC_LAST;
                end
                ST_CRC_LAST:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_EMIT_RD;
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_byte_reg  <= gen_byte;
                    out_fv_reg    <= 1'b1;
                    out_last_reg  <= (idx_reg == IDX_W'(FRAME_BYTES - 1));
                    out_ev_reg    <= ev_reg;
                    state_reg     <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + IDX_W'(1);
                        state_reg     <= out_last_reg ? ST_IDLE : ST_EMIT_RD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_ph_reg, out_ev_reg, out_byte_reg};
    assign m_tuser  = out_fv_reg;
    assign m_tlast  = out_last_reg;

    a_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (state_reg == ST_OUT_WAIT))
        else $error("result shown outside the output wait state");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result is pending");

    a_frame_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (out_ph_reg == PH_ERASE || out_ph_reg == PH_PROG
                                   || out_ph_reg == PH_VERIFY))
        else $error("frame byte sent outside an active phase");

    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        retry_reg != MAX_TRIES)
        else $error("retry count reached the fatal limit");

endmodule

[test/firmware_update_frame_sequencer_test.sv]
// testbench for the firmware update frame sequencer: directed table plus random update runs
module firmware_update_frame_sequencer_test;
    import fus_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 320;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fvalid;
        logic       flast;
        event_t     ev;
        phase_t     ph;
    } beat_t;

    typedef struct {
        bit          is_cfg;
        logic [15:0] val;
        cmd_t        c;
        logic [7:0]  d;
        logic [7:0]  r;
        bit          typed;
        event_t      ev;
        phase_t      ph;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // predictor state
    phase_t      upd_phase = PH_INIT;
    logic [10:0] chunk = '0;
    logic [1:0]  tries = '0;
    logic [15:0] img_size = '0;
    logic [7:0]  store_mem [IMAGE_DEPTH];
    bit          store_set [IMAGE_DEPTH];
    logic [7:0]  frm [FRAME_BYTES];

    beat_t frame_q [$];
    row_t  dir_tab [$];
    int    errors = 0;
    int    items_sent = 0;
    int    beats_seen = 0;
    int    cfg_writes = 0;
    int    idle_cycles = 0;
    int    gap_pct = 6;
    int    stall_pct = 67;

    firmware_update_frame_sequencer u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [15:0] frame_crc16();
        logic [15:0] c;
        c = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            c ^= {frm[i], 8'h00};
            for (int b = 0; b < 8; b++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic seal_and_push(input event_t ev);
        logic [15:0] c;
        frm[2] = 8'h00;
        frm[3] = 8'h00;
        c = frame_crc16();
        frm[2] = c[7:0];
        frm[3] = c[15:8];
        for (int k = 0; k < FRAME_BYTES; k++)
            frame_q.push_back('{frm[k], 1'b1, k == FRAME_BYTES - 1, ev, upd_phase});
    endtask

    task automatic push_status(input event_t ev);
        frame_q.push_back('{8'h00, 1'b0, 1'b1, ev, upd_phase});
    endtask

    task automatic put_le32(input int at, input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            frm[at + i] = v[8*i +: 8];
    endtask

    task automatic make_erase(input event_t ev);
        foreach (frm[i])
            frm[i] = 8'h00;
        frm[1] = 8'h08;
        put_le32(8, 32'(img_size) - 32'd1);
        upd_phase = PH_ERASE;
        seal_and_push(ev);
    endtask

    task automatic make_chunk(input bit prog);
        logic [31:0] base;
        int n;
        base = 32'(chunk) * PAYLOAD_BYTES;
        n = (base + PAYLOAD_BYTES > 32'(img_size)) ? int'(img_size) % PAYLOAD_BYTES
                                                  : PAYLOAD_BYTES;
        foreach (frm[i])
            frm[i] = 8'h00;
        frm[0] = 8'h01;
        frm[1] = {7'd0, prog};
        put_le32(4, base);
        put_le32(8, base + PAYLOAD_BYTES - 1);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            frm[HDR_BYTES + i] = (i < n) ? store_mem[16'(base + i)] : 8'hFF;
        upd_phase = prog ? PH_PROG : PH_VERIFY;
        chunk = chunk + 11'd1;
        seal_and_push(EV_NONE);
    endtask

    // expected results of one accepted item
    task automatic predict_update(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                                  input logic [7:0] r);
        phase_t p0;
        bit retry;
        bit done;
        p0 = upd_phase;
        done = 0;
        case (c)
            CMD_LOAD:
            begin
                store_mem[a] = d;
                store_set[a] = 1;
            end
            CMD_START:
                if (upd_phase == PH_INIT && img_size <= SIZE_LIMIT)
                    tries = '0;
            CMD_RESP:
                if (p0 == PH_ERASE || p0 == PH_PROG || p0 == PH_VERIFY)
                begin
                    if (r == FAIL_CODE)
                    begin
                        tries = tries + 2'd1;
                        if (tries >= MAX_TRIES)
                        begin
                            tries = '0;
                            upd_phase = PH_INIT;
                            push_status(EV_FATAL_RSP);
                            done = 1;
                        end
                    end
                    else
                        tries = '0;
                    retry = (tries != 0);
                    if (!done && p0 == PH_ERASE)
                    begin
                        if (retry)
                        begin
                            make_erase(EV_NONE);
                            done = 1;
                        end
                        else
                            chunk = '0;
                    end
                    if (!done && (p0 == PH_ERASE || p0 == PH_PROG))
                    begin
                        if (retry && p0 == PH_PROG && chunk > 0)
                            chunk = chunk - 11'd1;
                        if (32'(chunk) * PAYLOAD_BYTES < 32'(img_size))
                        begin
                            make_chunk(1);
                            done = 1;
                        end
                        else
                            chunk = '0;
                    end
                    if (!done)
                    begin
                        if (retry && p0 == PH_VERIFY && chunk > 0)
                            chunk = chunk - 11'd1;
                        if (32'(chunk) * PAYLOAD_BYTES < 32'(img_size))
                            make_chunk(0);
                        else
                        begin
                            upd_phase = PH_RESET;
                            push_status(EV_COMPLETE);
                        end
                    end
                end
                else
                    tries = '0;
            CMD_TIMEOUT:
                case (p0)
                    PH_INIT:
                        if (img_size == 0)
                        begin
                            upd_phase = PH_RESET;
                            push_status(EV_ENTER);
                        end
                        else
                            make_erase(EV_ENTER);
                    PH_RESET:
                    begin
                        upd_phase = PH_INIT;
                        push_status(EV_RESET);
                    end
                    default:
                    begin
                        tries = '0;
                        upd_phase = PH_INIT;
                        push_status(EV_FATAL_TMO);
                    end
                endcase
        endcase
    endtask

    task automatic send_item(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                             input logic [7:0] r);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {r, d, a};
        s_tuser = c;
        do
            @(posedge clk);
        while (!s_tready);
        predict_update(c, a, d, r);
        items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // config is written only once all frames are out and the block has settled
    task automatic write_size(input logic [15:0] v);
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        img_size = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(input bit is_cfg, input logic [15:0] val, input cmd_t c,
                           input logic [7:0] r, input bit typed = 0,
                           input event_t ev = EV_NONE, input phase_t ph = PH_INIT);
        dir_tab.push_back('{is_cfg, val, c, 8'h00, r, typed, ev, ph});
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tuser, m_tlast, event_t'(m_tdata[10:8]),
                    phase_t'(m_tdata[13:11])};
            beats_seen++;
            if (frame_q.size() == 0)
                report($sformatf("unexpected transfer %h", m_tdata));
            else
            begin
                want = frame_q.pop_front();
                if (got.fbyte !== want.fbyte)
                    report($sformatf("frame_byte %h, want %h", got.fbyte, want.fbyte));
                if (got.fvalid !== want.fvalid)
                    report($sformatf("frame_valid %b, want %b", got.fvalid, want.fvalid));
                if (got.flast !== want.flast)
                    report($sformatf("frame_last %b, want %b", got.flast, want.flast));
                if (got.ev !== want.ev)
                    report($sformatf("event %0d, want %0d", got.ev, want.ev));
                if (got.ph !== want.ph)
                    report($sformatf("phase %0d, want %0d", got.ph, want.ph));
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int rnd_start;
        int sz;
        int pick;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a 53-byte image covers a full chunk and a padded one
        for (int i = 0; i < 120; i++)
            send_item(CMD_LOAD, 16'(i), 8'($urandom), 8'h00);
        send_item(CMD_LOAD, 16'hFFFF, 8'hFF, 8'hFF);

        add_row(1, 16'd0, CMD_LOAD, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_ENTER, PH_RESET);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_RESET, PH_INIT);
        add_row(1, 16'd53, CMD_LOAD, 8'h00);
        add_row(0, 16'd0, CMD_START, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_RESP, FAIL_CODE);
        add_row(0, 16'd0, CMD_RESP, FAIL_CODE);
        add_row(0, 16'd0, CMD_RESP, FAIL_CODE, 1, EV_FATAL_RSP, PH_INIT);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_RESP, FAIL_CODE);   // resend of the padded chunk
        add_row(0, 16'd0, CMD_RESP, 8'hFF);
        add_row(0, 16'd0, CMD_RESP, 8'h47);
        add_row(0, 16'd0, CMD_RESP, 8'h45, 1, EV_COMPLETE, PH_RESET);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_RESET, PH_INIT);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_FATAL_TMO, PH_INIT);
        add_row(1, SIZE_LIMIT, CMD_LOAD, 8'h00);
        add_row(0, 16'd0, CMD_START, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_FATAL_TMO, PH_INIT);
        add_row(1, 16'hFFFF, CMD_LOAD, 8'h00);
        add_row(0, 16'd0, CMD_START, 8'h00);      // too large, ignored
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_FATAL_TMO, PH_INIT);
        add_row(1, 16'd52, CMD_LOAD, 8'h00);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00);
        add_row(0, 16'd0, CMD_RESP, 8'h00, 1, EV_COMPLETE, PH_RESET);
        add_row(0, 16'd0, CMD_TIMEOUT, 8'h00, 1, EV_RESET, PH_INIT);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_size(dir_tab[i].val);
            else
            begin
                send_item(dir_tab[i].c, dir_tab[i].val, dir_tab[i].d, dir_tab[i].r);
                if (dir_tab[i].typed)
                begin
                    void'(frame_q.pop_back());
                    frame_q.push_back('{8'h00, 1'b0, 1'b1, dir_tab[i].ev, dir_tab[i].ph});
                end
            end
        end

        rnd_start = items_sent;
        while (items_sent - rnd_start < RANDOM_ITEMS)
        begin
            if (items_sent - rnd_start < RANDOM_ITEMS / 3)
            begin
                gap_pct = 6;
                stall_pct = 67;
            end
            else if (items_sent - rnd_start < 2 * RANDOM_ITEMS / 3)
            begin
                gap_pct = 67;
                stall_pct = 6;
            end
            else
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            pick = $urandom_range(0, 9);
            sz = (pick == 0) ? 104 : (pick == 1) ? 155 : $urandom_range(1, 160);
            write_size(16'(sz));
            // every byte an update can read is written first
            for (int i = 0; i < sz; i++)
                if (!store_set[i])
                    send_item(CMD_LOAD, 16'(i), 8'($urandom), 8'h00);
            send_item(CMD_START, 16'($urandom), 8'($urandom), 8'($urandom));
            repeat ($urandom_range(4, 25))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_item(CMD_LOAD, 16'($urandom), 8'($urandom), 8'($urandom));
                else if (pick < 11)
                    send_item(CMD_START, 16'($urandom), 8'($urandom), 8'($urandom));
                else if (pick < 16 || upd_phase == PH_INIT || upd_phase == PH_RESET)
                    send_item(CMD_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_item(CMD_RESP, 16'($urandom), 8'($urandom),
                              ($urandom_range(0, 9) == 0) ? FAIL_CODE : 8'($urandom));
            end
            while (upd_phase != PH_INIT)
                send_item(CMD_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
        end

        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run: %0d input transfers, %0d output transfers, %0d size writes",
                 items_sent, beats_seen, cfg_writes);
        $display("covered erase, program and verify with retries, fatal and timeout exits");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/fus_pkg.sv
hw/rtl/fus_crc.sv
hw/rtl/fus_frame.sv
hw/rtl/firmware_update_frame_sequencer.sv
test/firmware_update_frame_sequencer_test.sv
